FILE: sv/sadu_pkg.sv
// ----------------------------------------------------------------------------
// sadu_pkg
// shared types for the signed add / divide unit: opcodes and the control
// flags that travel down the pipeline next to the data
// ----------------------------------------------------------------------------
`default_nettype none

package sadu_pkg;

    // operation selector
    typedef enum logic {
        OP_ADD = 1'b0,
        OP_DIV = 1'b1
    } t_opcode;

    // per-beat control flags carried through every stage
    typedef struct packed {
        t_opcode op;
        logic    err;
        logic    neg_q;
        logic    neg_r;
    } t_ctl;

endpackage

`default_nettype wire

FILE: sv/sadu_if.sv
// ----------------------------------------------------------------------------
// sadu_in_if / sadu_out_if
// valid / ready channels for operation beats and result beats
// ----------------------------------------------------------------------------
`default_nettype none

interface sadu_in_if #(
    parameter int DATA_WIDTH = 32
);
    logic                         valid;
    logic                         ready;
    logic                         opcode;
    logic signed [DATA_WIDTH-1:0] operand_a;
    logic signed [DATA_WIDTH-1:0] operand_b;

    modport source (output valid, input ready, output opcode, output operand_a,
                    output operand_b);
    modport sink (input valid, output ready, input opcode, input operand_a,
                  input operand_b);
endinterface

interface sadu_out_if #(
    parameter int DATA_WIDTH = 32
);
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] result_value;
    logic signed [DATA_WIDTH-1:0] remainder_value;
    logic                         error_flag;

    modport source (output valid, input ready, output result_value,
                    output remainder_value, output error_flag);
    modport sink (input valid, output ready, input result_value,
                  input remainder_value, input error_flag);
endinterface

`default_nettype wire

FILE: sv/sadu_prep.sv
// ----------------------------------------------------------------------------
// sadu_prep
// entry stage: decodes the opcode, forms the sum for add, and the operand
// magnitudes, result signs and divide-by-zero flag for divide
// ----------------------------------------------------------------------------
`default_nettype none

module sadu_prep #(
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    output logic                       o_ready,
    input  wire logic                  i_opcode,
    input  wire logic [DATA_WIDTH-1:0] i_operand_a,
    input  wire logic [DATA_WIDTH-1:0] i_operand_b,
    output logic                       o_valid,
    input  wire logic                  i_ready,
    output logic [DATA_WIDTH-1:0]      o_rem,
    output logic [DATA_WIDTH-1:0]      o_quo,
    output logic [DATA_WIDTH-1:0]      o_div,
    output sadu_pkg::t_ctl             o_ctl
);
    import sadu_pkg::*;

    logic                  r_valid;
    logic [DATA_WIDTH-1:0] r_quo;
    logic [DATA_WIDTH-1:0] r_div;
    t_ctl                  r_ctl;
    logic [DATA_WIDTH-1:0] n_quo;
    logic [DATA_WIDTH-1:0] n_div;
    t_ctl                  n_ctl;
    logic                  w_neg_a;
    logic                  w_neg_b;
    logic                  w_load;

    // stage handshake: take a beat when empty or when the next stage drains
    assign o_ready = !r_valid || i_ready;
    assign w_load  = i_valid && o_ready;

    // decode and operand conditioning
    always_comb begin
        w_neg_a   = i_operand_a[DATA_WIDTH-1];
        w_neg_b   = i_operand_b[DATA_WIDTH-1];
        n_ctl.op  = t_opcode'(i_opcode);
        n_ctl.err = (n_ctl.op == OP_DIV) && (i_operand_b == '0);
        n_ctl.neg_q = w_neg_a ^ w_neg_b;
        n_ctl.neg_r = w_neg_a;
        n_quo = w_neg_a ? ('0 - i_operand_a) : i_operand_a;
        if (n_ctl.op == OP_ADD) begin
            // the sum rides in the divisor slot, which the steps leave alone
            n_div = i_operand_a + i_operand_b;
        end else begin
            n_div = w_neg_b ? ('0 - i_operand_b) : i_operand_b;
        end
    end

    // valid bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_quo <= n_quo;
            r_div <= n_div;
            r_ctl <= n_ctl;
        end
    end

    assign o_valid = r_valid;
    assign o_rem   = '0;
    assign o_quo   = r_quo;
    assign o_div   = r_div;
    assign o_ctl   = r_ctl;

endmodule

`default_nettype wire

FILE: sv/sadu_step.sv
// ----------------------------------------------------------------------------
// sadu_step
// one restoring division step: shifts one dividend bit into the partial
// remainder, trial-subtracts the divisor and shifts in one quotient bit
// ----------------------------------------------------------------------------
`default_nettype none

module sadu_step #(
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    output logic                       o_ready,
    input  wire logic [DATA_WIDTH-1:0] i_rem,
    input  wire logic [DATA_WIDTH-1:0] i_quo,
    input  wire logic [DATA_WIDTH-1:0] i_div,
    input  wire sadu_pkg::t_ctl        i_ctl,
    output logic                       o_valid,
    input  wire logic                  i_ready,
    output logic [DATA_WIDTH-1:0]      o_rem,
    output logic [DATA_WIDTH-1:0]      o_quo,
    output logic [DATA_WIDTH-1:0]      o_div,
    output sadu_pkg::t_ctl             o_ctl
);
    import sadu_pkg::*;

    logic                  r_valid;
    logic [DATA_WIDTH-1:0] r_rem;
    logic [DATA_WIDTH-1:0] r_quo;
    logic [DATA_WIDTH-1:0] r_div;
    t_ctl                  r_ctl;
    logic [DATA_WIDTH-1:0] n_rem;
    logic [DATA_WIDTH-1:0] n_quo;
    logic [DATA_WIDTH:0]   w_trial;
    logic [DATA_WIDTH:0]   w_diff;
    logic                  w_load;

    assign o_ready = !r_valid || i_ready;
    assign w_load  = i_valid && o_ready;

    // trial subtract; a clear top bit means the divisor fits
    always_comb begin
        w_trial = {i_rem, i_quo[DATA_WIDTH-1]};
        w_diff  = w_trial - {1'b0, i_div};
        if (!w_diff[DATA_WIDTH]) begin
            n_rem = w_diff[DATA_WIDTH-1:0];
            n_quo = {i_quo[DATA_WIDTH-2:0], 1'b1};
        end else begin
            n_rem = w_trial[DATA_WIDTH-1:0];
            n_quo = {i_quo[DATA_WIDTH-2:0], 1'b0};
        end
    end

    // valid bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
            r_div <= i_div;
            r_ctl <= i_ctl;
        end
    end

    assign o_valid = r_valid;
    assign o_rem   = r_rem;
    assign o_quo   = r_quo;
    assign o_div   = r_div;
    assign o_ctl   = r_ctl;

endmodule

`default_nettype wire

FILE: sv/sadu_fix.sv
// ----------------------------------------------------------------------------
// sadu_fix
// output stage: applies the result signs, selects the sum for add, forces
// zeros on divide by zero, and holds the result beat for the receiver
// ----------------------------------------------------------------------------
`default_nettype none

module sadu_fix #(
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    output logic                       o_ready,
    input  wire logic [DATA_WIDTH-1:0] i_rem,
    input  wire logic [DATA_WIDTH-1:0] i_quo,
    input  wire logic [DATA_WIDTH-1:0] i_div,
    input  wire sadu_pkg::t_ctl        i_ctl,
    output logic                       o_valid,
    input  wire logic                  i_ready,
    output logic [DATA_WIDTH-1:0]      o_result_value,
    output logic [DATA_WIDTH-1:0]      o_remainder_value,
    output logic                       o_error_flag
);
    import sadu_pkg::*;

    logic                  r_valid;
    logic [DATA_WIDTH-1:0] r_result;
    logic [DATA_WIDTH-1:0] r_remainder;
    logic                  r_error;
    logic [DATA_WIDTH-1:0] n_result;
    logic [DATA_WIDTH-1:0] n_remainder;
    logic                  n_error;
    logic                  w_load;

    assign o_ready = !r_valid || i_ready;
    assign w_load  = i_valid && o_ready;

    // result selection and sign fixup
    always_comb begin
        n_result    = '0;
        n_remainder = '0;
        n_error     = 1'b0;
        if (i_ctl.op == OP_ADD) begin
            n_result = i_div;
        end else if (i_ctl.err) begin
            n_error = 1'b1;
        end else begin
            n_result    = i_ctl.neg_q ? ('0 - i_quo) : i_quo;
            n_remainder = i_ctl.neg_r ? ('0 - i_rem) : i_rem;
        end
    end

    // valid bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_result    <= n_result;
            r_remainder <= n_remainder;
            r_error     <= n_error;
        end
    end

    assign o_valid           = r_valid;
    assign o_result_value    = r_result;
    assign o_remainder_value = r_remainder;
    assign o_error_flag      = r_error;

endmodule

`default_nettype wire

FILE: sv/signed_add_divide_unit.sv
// ----------------------------------------------------------------------------
// signed_add_divide_unit
// pipelined signed add and divide-with-remainder on two's complement operands
// ----------------------------------------------------------------------------
// usage:
//   i_op carries operation beats (opcode, operand_a, operand_b); o_res
//   carries result beats (result_value, remainder_value, error_flag), one
//   per operation, in order. add wraps; divide truncates toward zero and
//   the remainder takes the dividend's sign; divide by zero gives zeros
//   with error_flag set; the most negative value over -1 gives itself.
//   the path from accept to result valid runs through one entry stage, one
//   restoring step stage per quotient bit and one output stage.
//   throughput is one beat per cycle while o_res is ready; every stage
//   holds a valid bit and the stages form a chain of one-deep buffers, so
//   a stall at o_res holds the beats in place while empty stages upstream
//   keep filling. nothing is dropped or repeated under any stall pattern.
//   synchronous active-low reset clears all valid bits; the unit keeps no
//   other state.
// ----------------------------------------------------------------------------
`default_nettype none

module signed_add_divide_unit #(
    parameter int DATA_WIDTH = 32
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    sadu_in_if.sink    i_op,
    sadu_out_if.source o_res
);
    import sadu_pkg::*;

    // the entry stage drives index 0, step k drives index k+1; index DATA_WIDTH feeds the output stage
    logic                  s_valid [0:DATA_WIDTH];
    logic                  s_ready [0:DATA_WIDTH];
    logic [DATA_WIDTH-1:0] s_rem   [0:DATA_WIDTH];
    logic [DATA_WIDTH-1:0] s_quo   [0:DATA_WIDTH];
    logic [DATA_WIDTH-1:0] s_div   [0:DATA_WIDTH];
    t_ctl                  s_ctl   [0:DATA_WIDTH];
    logic [DATA_WIDTH-1:0] w_result;
    logic [DATA_WIDTH-1:0] w_remainder;

    // entry stage
    sadu_prep #(.DATA_WIDTH(DATA_WIDTH)) u_prep (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_op.valid),
        .o_ready     (i_op.ready),
        .i_opcode    (i_op.opcode),
        .i_operand_a (i_op.operand_a),
        .i_operand_b (i_op.operand_b),
        .o_valid     (s_valid[0]),
        .i_ready     (s_ready[0]),
        .o_rem       (s_rem[0]),
        .o_quo       (s_quo[0]),
        .o_div       (s_div[0]),
        .o_ctl       (s_ctl[0])
    );

    // one step stage per quotient bit
    for (genvar k = 0; k < DATA_WIDTH; k++) begin : g_step
        sadu_step #(.DATA_WIDTH(DATA_WIDTH)) u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (s_valid[k]),
            .o_ready (s_ready[k]),
            .i_rem   (s_rem[k]),
            .i_quo   (s_quo[k]),
            .i_div   (s_div[k]),
            .i_ctl   (s_ctl[k]),
            .o_valid (s_valid[k+1]),
            .i_ready (s_ready[k+1]),
            .o_rem   (s_rem[k+1]),
            .o_quo   (s_quo[k+1]),
            .o_div   (s_div[k+1]),
            .o_ctl   (s_ctl[k+1])
        );
    end

    // output stage
    sadu_fix #(.DATA_WIDTH(DATA_WIDTH)) u_fix (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (s_valid[DATA_WIDTH]),
        .o_ready           (s_ready[DATA_WIDTH]),
        .i_rem             (s_rem[DATA_WIDTH]),
        .i_quo             (s_quo[DATA_WIDTH]),
        .i_div             (s_div[DATA_WIDTH]),
        .i_ctl             (s_ctl[DATA_WIDTH]),
        .o_valid           (o_res.valid),
        .i_ready           (o_res.ready),
        .o_result_value    (w_result),
        .o_remainder_value (w_remainder),
        .o_error_flag      (o_res.error_flag)
    );

    assign o_res.result_value    = $signed(w_result);
    assign o_res.remainder_value = $signed(w_remainder);

endmodule

`default_nettype wire

FILE: tb/tb_signed_add_divide_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_signed_add_divide_unit
// self-checking bench for the signed add / divide unit: a short table of
// directed beats (wrap-around, divide by zero, most negative over -1, every
// sign mix) followed by random bursts under random output backpressure.
// every accepted beat is scored against its table answer or an in-bench model of add and
// truncating divide, and results are checked in order, field by field
// ----------------------------------------------------------------------------

module tb_signed_add_divide_unit;

    import sadu_pkg::*;

    localparam int DW           = 32;
    localparam int RST_CYCLES   = 9;
    localparam int N_RANDOM     = 1030;
    localparam int HOLD_AT      = 300;   // beats in before the long output hold-off
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_AT     = 600;   // beats in before the sender waits for all results
    localparam int TAIL_CYCLES  = DW + 2 + 16;
    localparam int IDLE_LIMIT   = 2000;
    localparam logic [DW-1:0] MOST_NEG = {1'b1, {(DW-1){1'b0}}};
    localparam logic [DW-1:0] MOST_POS = {1'b0, {(DW-1){1'b1}}};

    // one result beat as the unit should produce it
    typedef struct packed {
        logic [DW-1:0] res_val;
        logic [DW-1:0] rem_val;
        logic          err_flag;
    } t_outcome;

    // one row of the directed table
    typedef struct packed {
        t_opcode       op;
        logic [DW-1:0] opa;
        logic [DW-1:0] opb;
        logic          typed;
        t_outcome      want;
    } t_vector;

    logic i_clk = 1'b0;
    logic i_rst_n;

    sadu_in_if  #(.DATA_WIDTH(DW)) op_if ();
    sadu_out_if #(.DATA_WIDTH(DW)) res_if ();

    signed_add_divide_unit #(
        .DATA_WIDTH(DW)
    ) uut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_op   (op_if),
        .o_res  (res_if)
    );

    // bench state shared by sender, receiver and scoreboard
    logic     stim_typed;
    t_outcome stim_want;
    t_outcome owed_results [$];
    int       n_beats_in  = 0;
    int       n_beats_out = 0;
    int       n_fail      = 0;
    int       idle_cycles = 0;

    // directed beats; typed rows carry their answer, the rest go to the model
    t_vector dir_table [22] = '{
        '{OP_ADD, 32'h0000_0000, 32'h0000_0000, 1'b1, '{32'h0000_0000, 32'h0, 1'b0}},
        '{OP_ADD, 32'h7FFF_FFFF, 32'h0000_0001, 1'b1, '{32'h8000_0000, 32'h0, 1'b0}},
        '{OP_ADD, 32'h8000_0000, 32'h8000_0000, 1'b1, '{32'h0000_0000, 32'h0, 1'b0}},
        '{OP_ADD, 32'hFFFF_FFFF, 32'h0000_0001, 1'b1, '{32'h0000_0000, 32'h0, 1'b0}},
        '{OP_ADD, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1, '{32'hFFFF_FFFE, 32'h0, 1'b0}},
        '{OP_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, '{32'hFFFF_FFFE, 32'h0, 1'b0}},
        '{OP_ADD, 32'h1234_5678, 32'h9ABC_DEF0, 1'b0, '0},
        '{OP_DIV, 32'h0000_0005, 32'h0000_0000, 1'b1, '{32'h0000_0000, 32'h0, 1'b1}},
        '{OP_DIV, 32'h8000_0000, 32'h0000_0000, 1'b1, '{32'h0000_0000, 32'h0, 1'b1}},
        '{OP_DIV, 32'h0000_0000, 32'h0000_0000, 1'b1, '{32'h0000_0000, 32'h0, 1'b1}},
        '{OP_DIV, 32'h8000_0000, 32'hFFFF_FFFF, 1'b1, '{32'h8000_0000, 32'h0, 1'b0}},
        '{OP_DIV, 32'h0000_0007, 32'h0000_0002, 1'b1, '{32'h0000_0003, 32'h1, 1'b0}},
        '{OP_DIV, 32'hFFFF_FFF9, 32'h0000_0002, 1'b1,
          '{32'hFFFF_FFFD, 32'hFFFF_FFFF, 1'b0}},
        '{OP_DIV, 32'h0000_0007, 32'hFFFF_FFFE, 1'b1, '{32'hFFFF_FFFD, 32'h1, 1'b0}},
        '{OP_DIV, 32'hFFFF_FFF9, 32'hFFFF_FFFE, 1'b1,
          '{32'h0000_0003, 32'hFFFF_FFFF, 1'b0}},
        '{OP_DIV, 32'h8000_0000, 32'h0000_0001, 1'b1, '{32'h8000_0000, 32'h0, 1'b0}},
        '{OP_DIV, 32'h7FFF_FFFF, 32'h0000_0001, 1'b1, '{32'h7FFF_FFFF, 32'h0, 1'b0}},
        '{OP_DIV, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1,
          '{32'h0000_0000, 32'h7FFF_FFFF, 1'b0}},
        '{OP_DIV, 32'h8000_0000, 32'h8000_0000, 1'b1, '{32'h0000_0001, 32'h0, 1'b0}},
        '{OP_DIV, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1,
          '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0}},
        '{OP_DIV, 32'h0000_0000, 32'h0000_0005, 1'b1, '{32'h0000_0000, 32'h0, 1'b0}},
        '{OP_DIV, 32'hDEAD_BEEF, 32'h0000_1234, 1'b0, '0}
    };

    // clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // reset, held once at the start
    initial begin
        i_rst_n <= 1'b0;
        repeat (RST_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // wrapping add, or divide truncated toward zero with the dividend's sign
    // on the remainder; divide by zero flags and zeros both fields
    function automatic t_outcome predict_outcome(input t_opcode op, input logic [DW-1:0] a,
                                                 input logic [DW-1:0] b);
        t_outcome      o;
        logic          neg_a;
        logic          neg_b;
        logic [DW-1:0] mag_a;
        logic [DW-1:0] mag_b;
        logic [DW-1:0] quo;
        logic [DW-1:0] rmd;
        o = '0;
        if (op == OP_ADD) begin
            o.res_val = a + b;
        end else if (b == '0) begin
            o.err_flag = 1'b1;
        end else begin
            neg_a     = a[DW-1];
            neg_b     = b[DW-1];
            mag_a     = neg_a ? -a : a;
            mag_b     = neg_b ? -b : b;
            quo       = mag_a / mag_b;
            rmd       = mag_a % mag_b;
            o.res_val = (neg_a != neg_b) ? -quo : quo;
            o.rem_val = neg_a ? -rmd : rmd;
        end
        return o;
    endfunction

    // operand mix: full width, small values, shifted values, powers of two, extremes
    function automatic logic [DW-1:0] rand_operand();
        logic [DW-1:0] v;
        v = $urandom();
        case ($urandom_range(0, 9))
            4, 5: begin
                v = $urandom_range(0, 200);
                v = v - 100;
            end
            6: begin
                v = v >> $urandom_range(1, DW - 1);
                if ($urandom_range(0, 1) == 1) v = -v;
            end
            7, 8: begin
                case ($urandom_range(0, 4))
                    0: v = MOST_NEG;
                    1: v = MOST_POS;
                    2: v = '1;
                    3: v = '0;
                    default: v = 1;
                endcase
            end
            9: begin
                v = 1 << $urandom_range(0, DW - 1);
                if ($urandom_range(0, 1) == 1) v = -v;
            end
            default: ;
        endcase
        return v;
    endfunction

    task automatic report_fail(input string what, input t_outcome want, input t_outcome got);
        n_fail++;
        if (n_fail <= 10)
            $display("[%0t] %s: expected res=%h rem=%h err=%b, got res=%h rem=%h err=%b",
                     $time, what, want.res_val, want.rem_val, want.err_flag,
                     got.res_val, got.rem_val, got.err_flag);
    endtask

    // offer one operation beat from the current edge and wait until it is taken
    task automatic send_beat(input t_opcode op, input logic [DW-1:0] a,
                             input logic [DW-1:0] b, input logic typed, input t_outcome want);
        op_if.valid     <= 1'b1;
        op_if.opcode    <= op;
        op_if.operand_a <= a;
        op_if.operand_b <= b;
        stim_typed      <= typed;
        stim_want       <= want;
        @(posedge i_clk);
        while (!op_if.ready) @(posedge i_clk);
    endtask

    // scoreboard: queue the answer on each input beat, check each result beat
    always @(posedge i_clk) begin : score
        t_outcome got;
        t_outcome want;
        if (i_rst_n && op_if.valid && op_if.ready) begin
            if (stim_typed)
                owed_results.push_back(stim_want);
            else
                owed_results.push_back(predict_outcome(t_opcode'(op_if.opcode),
                                                       op_if.operand_a, op_if.operand_b));
            n_beats_in <= n_beats_in + 1;
        end
        if (i_rst_n && res_if.valid && res_if.ready) begin
            n_beats_out <= n_beats_out + 1;
            got = '{res_if.result_value, res_if.remainder_value, res_if.error_flag};
            if (owed_results.size() == 0) begin
                report_fail("result beat with nothing pending", '0, got);
            end else begin
                want = owed_results.pop_front();
                if (got.res_val !== want.res_val || got.rem_val !== want.rem_val ||
                    got.err_flag !== want.err_flag)
                    report_fail("result mismatch", want, got);
            end
        end
    end

    // watchdog on cycles with no beat moving on either side
    always @(posedge i_clk) begin
        if ((op_if.valid && op_if.ready) || (res_if.valid && res_if.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // result side pacing: segments of always-ready, random stalls, a fixed
    // pattern and heavy stalls, plus one long hold-off to back up the pipeline
    initial begin : sink_pace
        int unsigned mode;
        int unsigned span;
        int unsigned k;
        bit          held;
        logic        rdy;
        held = 1'b0;
        res_if.ready <= 1'b0;
        repeat (RST_CYCLES) @(posedge i_clk);
        forever begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(8, 64);
            for (k = 0; k < span; k++) begin
                if (!held && n_beats_in >= HOLD_AT) begin
                    held = 1'b1;
                    res_if.ready <= 1'b0;
                    repeat (HOLD_CYCLES) @(posedge i_clk);
                end
                case (mode)
                    0:       rdy = 1'b1;
                    1:       rdy = ($urandom_range(0, 99) >= 35);
                    2:       rdy = (k % 4 != 3);
                    default: rdy = ($urandom_range(0, 99) >= 80);
                endcase
                res_if.ready <= rdy;
                @(posedge i_clk);
            end
        end
    end

    // operation side: directed table, then random bursts, then drain and verdict
    initial begin : op_feed
        t_opcode       op;
        logic [DW-1:0] a;
        logic [DW-1:0] b;
        int unsigned   burst;
        int unsigned   gap;
        int unsigned   k;
        int unsigned   n_sent;
        bit            drained;
        op_if.valid     <= 1'b0;
        op_if.opcode    <= OP_ADD;
        op_if.operand_a <= '0;
        op_if.operand_b <= '0;
        stim_typed      <= 1'b0;
        stim_want       <= '0;
        repeat (RST_CYCLES + 1) @(posedge i_clk);

        // directed beats back to back
        foreach (dir_table[i])
            send_beat(dir_table[i].op, dir_table[i].opa, dir_table[i].opb,
                      dir_table[i].typed, dir_table[i].want);

        // random bursts with random gaps
        n_sent  = 0;
        drained = 1'b0;
        while (n_sent < N_RANDOM) begin
            burst = $urandom_range(1, 40);
            for (k = 0; k < burst && n_sent < N_RANDOM; k++) begin
                op = ($urandom_range(0, 99) < 60) ? OP_DIV : OP_ADD;
                a  = rand_operand();
                b  = rand_operand();
                if (op == OP_DIV) begin
                    case ($urandom_range(0, 49))
                        0, 1: b = '0;
                        2: begin
                            a = MOST_NEG;
                            b = '1;
                        end
                        3, 4, 5, 6, 7: b = $urandom_range(1, 20);
                        default: ;
                    endcase
                end
                send_beat(op, a, b, 1'b0, '0);
                n_sent++;
            end
            if (!drained && n_sent >= DRAIN_AT) begin
                // stop offering until every owed result is back
                drained = 1'b1;
                op_if.valid <= 1'b0;
                do @(posedge i_clk); while (n_beats_out != n_beats_in);
            end else begin
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                if (gap != 0) begin
                    op_if.valid <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
        end
        op_if.valid <= 1'b0;

        // wait out the results, then a tail wait for strays
        do @(posedge i_clk); while (n_beats_out != n_beats_in);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        if (n_fail == 0 && owed_results.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
